>>> rtl/core/fpvm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the phase voltage modulator.
// No dependencies.
package fpvm_pkg;

   localparam int ANGLE_STAGES = 3;
   localparam int MOD_STAGES = 10;
   localparam int PIPE_STAGES = ANGLE_STAGES + MOD_STAGES;

   localparam int ROTOR_WIDTH = 32;
   localparam int VOLT_WIDTH = 16;
   localparam int PHASE_WIDTH = 17;
   localparam int ELEC_ANGLE_WIDTH = 16;
   localparam int SINE_WIDTH = 15;
   localparam int CSR_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLE_PAIR_COUNT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATION_SIGN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELECTRICAL_ZERO = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUPPLY_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPACE_VECTOR_MODE = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_ENABLE = 3'd6;

   // direction factor codes (two bit signed)
   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_POS = 2'b01;
   localparam logic [1:0] DIR_NEG_TWO = 2'b10;
   localparam logic [1:0] DIR_NEG = 2'b11;

   localparam logic signed [15:0] SQRT3_HALF = 16'sd28378;
   localparam int PHASE_MAX = 65535;
   localparam int PHASE_MIN = -65536;
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint PI_HALF_Q30 = 64'sd1686629713;

   typedef logic signed [VOLT_WIDTH-1:0] volt_type;
   typedef logic signed [PHASE_WIDTH-1:0] phase_type;
   typedef logic [SINE_WIDTH-1:0] sine_type;

   typedef struct packed {
      logic [ANGLE_STAGES-1:0] angle_load;
      logic [MOD_STAGES-1:0]   mod_load;
   } pipe_ctrl_type;

endpackage

>>> rtl/core/fpvm_pipe_ctrl.sv
`timescale 1ns / 1ps
// Stage valid bits and per-stage load enables for the modulator pipeline.
// Depends on fpvm_pkg.
module fpvm_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fpvm_pkg::pipe_ctrl_type ctrl
);
   import fpvm_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] load;

   // a stage advances unless it and every stage after it are full and the output stalls
   for (genvar gi = 0; gi < PIPE_STAGES; gi++) begin : g_load
      assign load[gi] = !(rsp_stall && (&valid_ff[PIPE_STAGES-1:gi]));
   end

   assign valid_in = (load & {valid_ff[PIPE_STAGES-2:0], req_valid}) | (~load & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.angle_load = load[ANGLE_STAGES-1:0];
   assign ctrl.mod_load = load[PIPE_STAGES-1:ANGLE_STAGES];
   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   a_accept_fills_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall)
      |=> $countones(valid_ff) == $past($countones(valid_ff)))
      else $error("word count changed without a handshake");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) && !(rsp_valid && !rsp_stall)
      |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("accepted word not counted");

endmodule

>>> rtl/core/fpvm_angle.sv
`timescale 1ns / 1ps
// Electrical angle stages: shaft angle, pole pair scaling, quadrant and
// sine table address. Depends on fpvm_pkg.
module fpvm_angle #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  fpvm_pkg::pipe_ctrl_type                ctrl,
   input  logic [fpvm_pkg::ROTOR_WIDTH-1:0]       rotor_angle,
   input  logic                                   angle_is_mechanical,
   input  fpvm_pkg::volt_type                     volt_q,
   input  fpvm_pkg::volt_type                     volt_d,
   input  logic [6:0]                             pole_pair_count,
   input  logic [fpvm_pkg::ROTOR_WIDTH-1:0]       angle_offset,
   input  logic [1:0]                             rotation_sign,
   input  logic [15:0]                            electrical_zero,
   output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  sine_addr,
   output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  cosine_addr,
   output logic                                   sine_neg,
   output logic                                   cosine_neg,
   output fpvm_pkg::volt_type                     volt_q_out,
   output fpvm_pkg::volt_type                     volt_d_out,
   output logic [fpvm_pkg::ELEC_ANGLE_WIDTH-1:0]  elec_angle
);
   import fpvm_pkg::*;

   localparam int TB = ANGLE_FRAC_BITS;
   localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int FRAC_BITS = ANGLE_FRAC_BITS - 2;
   localparam int PW = FRAC_BITS + AW;
   localparam logic [AW-1:0] DEPTH_CODE = AW'(SINE_TABLE_DEPTH);

   // stage 0: shaft angle
   logic [TB-1:0] diff;
   logic [TB-1:0] shaft_scaled;
   logic [TB-1:0] shaft_in;
   logic [TB-1:0] shaft_ff;
   logic          mech_ff;
   volt_type      vq0_ff;
   volt_type      vd0_ff;

   assign diff = rotor_angle[TB-1:0] - angle_offset[TB-1:0];

   always_comb begin
      case (rotation_sign)
         DIR_POS:     shaft_scaled = diff;
         DIR_NEG:     shaft_scaled = -diff;
         DIR_NEG_TWO: shaft_scaled = -(diff << 1);
         default:     shaft_scaled = '0;
      endcase
      shaft_in = angle_is_mechanical ? shaft_scaled : rotor_angle[TB-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.angle_load[0]) begin
         shaft_ff <= shaft_in;
         mech_ff <= angle_is_mechanical;
         vq0_ff <= volt_q;
         vd0_ff <= volt_d;
      end
   end

   // stage 1: electrical angle, one turn
   logic [TB+6:0]  turns_prod;
   logic [TB+15:0] zero_wide;
   logic [TB-1:0]  angle_in;
   logic [TB-1:0]  angle_ff;
   volt_type       vq1_ff;
   volt_type       vd1_ff;

   assign turns_prod = shaft_ff * pole_pair_count;
   assign zero_wide = {{TB{1'b0}}, electrical_zero};
   assign angle_in = mech_ff ? (turns_prod[TB-1:0] - zero_wide[TB-1:0]) : shaft_ff;

   always_ff @(posedge clock) begin
      if (ctrl.angle_load[1]) begin
         angle_ff <= angle_in;
         vq1_ff <= vq0_ff;
         vd1_ff <= vd0_ff;
      end
   end

   // stage 2: quadrant and table index
   logic [1:0]                  quad;
   logic [FRAC_BITS-1:0]        frac;
   logic [PW-1:0]               frac_prod;
   logic [AW-1:0]               idx;
   logic [AW-1:0]               sin_addr_in;
   logic [AW-1:0]               cos_addr_in;
   logic [ELEC_ANGLE_WIDTH-1:0] ang16_in;
   logic [AW-1:0]               sin_addr_ff;
   logic [AW-1:0]               cos_addr_ff;
   logic                        sin_neg_ff;
   logic                        cos_neg_ff;
   logic [ELEC_ANGLE_WIDTH-1:0] ang16_ff;
   volt_type                    vq2_ff;
   volt_type                    vd2_ff;

   assign quad = angle_ff[TB-1:TB-2];
   assign frac = angle_ff[FRAC_BITS-1:0];
   assign frac_prod = PW'(frac) * PW'(SINE_TABLE_DEPTH);
   assign idx = AW'(frac_prod >> FRAC_BITS);
   assign sin_addr_in = quad[0] ? (DEPTH_CODE - idx) : idx;
   assign cos_addr_in = quad[0] ? idx : (DEPTH_CODE - idx);

   if (TB >= ELEC_ANGLE_WIDTH) begin : g_ang_down
      assign ang16_in = angle_ff[TB-1:TB-ELEC_ANGLE_WIDTH];
   end else begin : g_ang_up
      assign ang16_in = {angle_ff, {(ELEC_ANGLE_WIDTH-TB){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (ctrl.angle_load[2]) begin
         sin_addr_ff <= sin_addr_in;
         cos_addr_ff <= cos_addr_in;
         sin_neg_ff <= quad[1];
         cos_neg_ff <= quad[1] ^ quad[0];
         ang16_ff <= ang16_in;
         vq2_ff <= vq1_ff;
         vd2_ff <= vd1_ff;
      end
   end

   assign sine_addr = sin_addr_ff;
   assign cosine_addr = cos_addr_ff;
   assign sine_neg = sin_neg_ff;
   assign cosine_neg = cos_neg_ff;
   assign volt_q_out = vq2_ff;
   assign volt_d_out = vd2_ff;
   assign elec_angle = ang16_ff;

endmodule

>>> rtl/core/fpvm_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine table with two registered read ports.
// Depends on fpvm_pkg for the table constants.
module fpvm_sine_rom #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] sine_addr,
   input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] cosine_addr,
   output fpvm_pkg::sine_type                    sine_mag,
   output fpvm_pkg::sine_type                    cosine_mag
);
   import fpvm_pkg::*;

   localparam int ENTRIES = SINE_TABLE_DEPTH + 1;

   sine_type rom_data [ENTRIES];
   sine_type sine_mag_ff;
   sine_type cosine_mag_ff;

   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_rom
      // sin(pi/2 * index / depth): integer Taylor series in Q30, rounded to Q15
      localparam longint X = (PI_HALF_Q30 * longint'(gi)) / longint'(SINE_TABLE_DEPTH);
      localparam longint T1 = -((((X * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd6;
      localparam longint T2 = -((((T1 * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd20;
      localparam longint T3 = -((((T2 * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd42;
      localparam longint T4 = -((((T3 * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd72;
      localparam longint T5 = -((((T4 * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd110;
      localparam longint T6 = -((((T5 * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd156;
      localparam longint T7 = -((((T6 * X) / Q30_ONE) * X) / Q30_ONE) / 64'sd210;
      localparam longint SUM = X + T1 + T2 + T3 + T4 + T5 + T6 + T7;
      localparam longint ROUNDED = (((SUM < 0) ? 64'sd0 : SUM) + 64'sd16384) / 64'sd32768;
      localparam longint CLAMPED = (ROUNDED > 64'sd32767) ? 64'sd32767 : ROUNDED;
      localparam sine_type ENTRY = SINE_WIDTH'(CLAMPED);
      assign rom_data[gi] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sine_mag_ff <= rom_data[sine_addr];
         cosine_mag_ff <= rom_data[cosine_addr];
      end
   end

   assign sine_mag = sine_mag_ff;
   assign cosine_mag = cosine_mag_ff;

endmodule

>>> rtl/core/fpvm_modulate.sv
`timescale 1ns / 1ps
// Inverse Park, inverse Clarke, zero-sequence offset, rounding and
// saturation stages. Depends on fpvm_pkg.
module fpvm_modulate (
   input  logic                                  clock,
   input  fpvm_pkg::pipe_ctrl_type               ctrl,
   input  logic                                  sine_neg,
   input  logic                                  cosine_neg,
   input  fpvm_pkg::sine_type                    sine_mag,
   input  fpvm_pkg::sine_type                    cosine_mag,
   input  fpvm_pkg::volt_type                    volt_q,
   input  fpvm_pkg::volt_type                    volt_d,
   input  logic [fpvm_pkg::ELEC_ANGLE_WIDTH-1:0] elec_angle_in,
   input  logic [14:0]                           supply_limit,
   input  logic                                  space_vector_mode,
   input  logic                                  center_enable,
   output fpvm_pkg::phase_type                   phase_a,
   output fpvm_pkg::phase_type                   phase_b,
   output fpvm_pkg::phase_type                   phase_c,
   output logic [fpvm_pkg::ELEC_ANGLE_WIDTH-1:0] elec_angle
);
   import fpvm_pkg::*;

   localparam int PROD_W = 2 * VOLT_WIDTH;
   localparam int ALPHA_W = PROD_W + 1;
   localparam int BETA_SC_W = ALPHA_W + 16;
   localparam int XW = 50;
   localparam int OW = 52;
   localparam int TW = 54;
   localparam int RW = TW - 31;
   localparam logic signed [TW-1:0] ROUND_HALF = TW'(32'sd1 <<< 30);

   function automatic phase_type saturate(input logic signed [TW-1:0] t);
      logic signed [RW-1:0] r;
      phase_type            sat;
      r = RW'(t >>> 31);
      if (r > RW'(PHASE_MAX)) begin
         sat = PHASE_WIDTH'(PHASE_MAX);
      end else if (r < RW'(PHASE_MIN)) begin
         sat = PHASE_WIDTH'(PHASE_MIN);
      end else begin
         sat = PHASE_WIDTH'(r);
      end
      return sat;
   endfunction

   // elec angle shift line
   logic [MOD_STAGES-1:0][ELEC_ANGLE_WIDTH-1:0] angle_line_ff;
   logic [MOD_STAGES-1:0][ELEC_ANGLE_WIDTH-1:0] angle_line_in;

   assign angle_line_in = {angle_line_ff[MOD_STAGES-2:0], elec_angle_in};

   always_ff @(posedge clock) begin
      for (int i = 0; i < MOD_STAGES; i++) begin
         if (ctrl.mod_load[i]) begin
            angle_line_ff[i] <= angle_line_in[i];
         end
      end
   end

   // m0: hold signs and volts beside the table read
   logic     sneg_ff;
   logic     cneg_ff;
   volt_type vq_ff;
   volt_type vd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[0]) begin
         sneg_ff <= sine_neg;
         cneg_ff <= cosine_neg;
         vq_ff <= volt_q;
         vd_ff <= volt_d;
      end
   end

   // m1: products
   logic signed [VOLT_WIDTH-1:0] sin_val;
   logic signed [VOLT_WIDTH-1:0] cos_val;
   logic signed [PROD_W-1:0]     prod_dc_in;
   logic signed [PROD_W-1:0]     prod_qs_in;
   logic signed [PROD_W-1:0]     prod_ds_in;
   logic signed [PROD_W-1:0]     prod_qc_in;
   logic signed [PROD_W-1:0]     prod_dc_ff;
   logic signed [PROD_W-1:0]     prod_qs_ff;
   logic signed [PROD_W-1:0]     prod_ds_ff;
   logic signed [PROD_W-1:0]     prod_qc_ff;

   assign sin_val = sneg_ff ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
   assign cos_val = cneg_ff ? -$signed({1'b0, cosine_mag}) : $signed({1'b0, cosine_mag});
   assign prod_dc_in = vd_ff * cos_val;
   assign prod_qs_in = vq_ff * sin_val;
   assign prod_ds_in = vd_ff * sin_val;
   assign prod_qc_in = vq_ff * cos_val;

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[1]) begin
         prod_dc_ff <= prod_dc_in;
         prod_qs_ff <= prod_qs_in;
         prod_ds_ff <= prod_ds_in;
         prod_qc_ff <= prod_qc_in;
      end
   end

   // m2: alpha and beta
   logic signed [ALPHA_W-1:0] alpha_in;
   logic signed [ALPHA_W-1:0] beta_in;
   logic signed [ALPHA_W-1:0] alpha_ff;
   logic signed [ALPHA_W-1:0] beta_ff;

   assign alpha_in = ALPHA_W'(prod_dc_ff) - ALPHA_W'(prod_qs_ff);
   assign beta_in = ALPHA_W'(prod_ds_ff) + ALPHA_W'(prod_qc_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[2]) begin
         alpha_ff <= alpha_in;
         beta_ff <= beta_in;
      end
   end

   // m3: phases a and b at 2^-31 of 1/256 V, halved
   logic signed [XW-1:0]        alpha_x;
   logic signed [BETA_SC_W-1:0] beta_scaled;
   logic signed [XW-1:0]        xa3_in;
   logic signed [XW-1:0]        xb3_in;
   logic signed [XW-1:0]        xa3_ff;
   logic signed [XW-1:0]        xb3_ff;

   assign alpha_x = XW'(alpha_ff);
   assign beta_scaled = beta_ff * SQRT3_HALF;
   assign xa3_in = alpha_x <<< 15;
   assign xb3_in = XW'(beta_scaled) - (alpha_x <<< 14);

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[3]) begin
         xa3_ff <= xa3_in;
         xb3_ff <= xb3_in;
      end
   end

   // m4: phase c
   logic signed [XW-1:0] xc4_in;
   logic signed [XW-1:0] xa4_ff;
   logic signed [XW-1:0] xb4_ff;
   logic signed [XW-1:0] xc4_ff;

   assign xc4_in = -(xa3_ff + xb3_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[4]) begin
         xa4_ff <= xa3_ff;
         xb4_ff <= xb3_ff;
         xc4_ff <= xc4_in;
      end
   end

   // m5: max and min of a and b
   logic signed [XW-1:0] xa5_ff;
   logic signed [XW-1:0] xb5_ff;
   logic signed [XW-1:0] xc5_ff;
   logic signed [XW-1:0] hi5_ff;
   logic signed [XW-1:0] lo5_ff;
   logic                 a_above_b;

   assign a_above_b = xa4_ff > xb4_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[5]) begin
         xa5_ff <= xa4_ff;
         xb5_ff <= xb4_ff;
         xc5_ff <= xc4_ff;
         hi5_ff <= a_above_b ? xa4_ff : xb4_ff;
         lo5_ff <= a_above_b ? xb4_ff : xa4_ff;
      end
   end

   // m6: fold in phase c
   logic signed [XW-1:0] xa6_ff;
   logic signed [XW-1:0] xb6_ff;
   logic signed [XW-1:0] xc6_ff;
   logic signed [XW-1:0] hi6_ff;
   logic signed [XW-1:0] lo6_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[6]) begin
         xa6_ff <= xa5_ff;
         xb6_ff <= xb5_ff;
         xc6_ff <= xc5_ff;
         hi6_ff <= (hi5_ff > xc5_ff) ? hi5_ff : xc5_ff;
         lo6_ff <= (lo5_ff < xc5_ff) ? lo5_ff : xc5_ff;
      end
   end

   // m7: doubled offset
   logic signed [OW-1:0] limit_q30;
   logic signed [OW-1:0] off7_in;
   logic signed [OW-1:0] off7_ff;
   logic signed [XW-1:0] xa7_ff;
   logic signed [XW-1:0] xb7_ff;
   logic signed [XW-1:0] xc7_ff;

   assign limit_q30 = OW'({supply_limit, 30'b0});

   always_comb begin
      if (space_vector_mode) begin
         off7_in = limit_q30 - OW'(hi6_ff) - OW'(lo6_ff);
      end else if (center_enable) begin
         off7_in = limit_q30;
      end else begin
         off7_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[7]) begin
         off7_ff <= off7_in;
         xa7_ff <= xa6_ff;
         xb7_ff <= xb6_ff;
         xc7_ff <= xc6_ff;
      end
   end

   // m8: add offset and rounding half
   logic signed [TW-1:0] ta8_ff;
   logic signed [TW-1:0] tb8_ff;
   logic signed [TW-1:0] tc8_ff;
   logic signed [TW-1:0] off_t;

   assign off_t = TW'(off7_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[8]) begin
         ta8_ff <= (TW'(xa7_ff) <<< 1) + off_t;
         tb8_ff <= (TW'(xb7_ff) <<< 1) + off_t;
         tc8_ff <= (TW'(xc7_ff) <<< 1) + off_t;
      end
   end

   // m9: floor to 1/256 V and saturate
   phase_type phase_a_ff;
   phase_type phase_b_ff;
   phase_type phase_c_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mod_load[9]) begin
         phase_a_ff <= saturate(ta8_ff);
         phase_b_ff <= saturate(tb8_ff);
         phase_c_ff <= saturate(tc8_ff);
      end
   end

   assign phase_a = phase_a_ff;
   assign phase_b = phase_b_ff;
   assign phase_c = phase_c_ff;
   assign elec_angle = angle_line_ff[MOD_STAGES-1];

endmodule

>>> rtl/core/foc_phase_voltage_modulator_core.sv
`timescale 1ns / 1ps
// Top level of the phase voltage modulator: control registers, pipeline
// control, angle stages, sine table and modulation stages. Depends on fpvm_pkg.
//
//   channel | direction | handshake          | contents
//   req     | in        | req_valid/req_stall | rotor angle, angle kind, volt q, volt d
//   rsp     | out       | rsp_valid/rsp_stall | phase a, b, c, electrical angle
//   csr     | in        | csr_write_enable    | register index and write data
//
// One word per cycle enters and leaves while rsp is not stalled.
// The pipeline has 13 register stages: 3 angle stages, the registered
// table read, and 9 modulation stages.
// Reset clears all stage valid bits and loads the register reset values.
// A stall on rsp fills empty stages first; req stalls only once all 13 hold words.
module foc_phase_voltage_modulator_core #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fpvm_pkg::ROTOR_WIDTH-1:0] req_rotor_angle,
   input  logic                                  req_angle_is_mechanical,
   input  fpvm_pkg::volt_type                    req_volt_q,
   input  fpvm_pkg::volt_type                    req_volt_d,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fpvm_pkg::phase_type                   rsp_phase_a,
   output fpvm_pkg::phase_type                   rsp_phase_b,
   output fpvm_pkg::phase_type                   rsp_phase_c,
   output logic [fpvm_pkg::ELEC_ANGLE_WIDTH-1:0] rsp_elec_angle,
   input  logic                                  csr_write_enable,
   input  logic [fpvm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fpvm_pkg::CSR_WIDTH-1:0]        csr_write_data
);
   import fpvm_pkg::*;

   localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

   logic [6:0]             pole_pair_count_ff;
   logic [ROTOR_WIDTH-1:0] angle_offset_ff;
   logic [1:0]             rotation_sign_ff;
   logic [15:0]            electrical_zero_ff;
   logic [14:0]            supply_limit_ff;
   logic                   space_vector_mode_ff;
   logic                   center_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_pair_count_ff <= 7'd7;
         angle_offset_ff <= '0;
         rotation_sign_ff <= DIR_ZERO;
         electrical_zero_ff <= '0;
         supply_limit_ff <= 15'd3072;
         space_vector_mode_ff <= 1'b1;
         center_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POLE_PAIR_COUNT:   pole_pair_count_ff <= csr_write_data[6:0];
            CSR_ANGLE_OFFSET:      angle_offset_ff <= csr_write_data[ROTOR_WIDTH-1:0];
            CSR_ROTATION_SIGN:     rotation_sign_ff <= csr_write_data[1:0];
            CSR_ELECTRICAL_ZERO:   electrical_zero_ff <= csr_write_data[15:0];
            CSR_SUPPLY_LIMIT:      supply_limit_ff <= csr_write_data[14:0];
            CSR_SPACE_VECTOR_MODE: space_vector_mode_ff <= csr_write_data[0];
            CSR_CENTER_ENABLE:     center_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   pipe_ctrl_type              ctrl;
   logic [AW-1:0]              sine_addr;
   logic [AW-1:0]              cosine_addr;
   logic                       sine_neg;
   logic                       cosine_neg;
   volt_type                   volt_q_st;
   volt_type                   volt_d_st;
   logic [ELEC_ANGLE_WIDTH-1:0] elec_angle_st;
   sine_type                   sine_mag;
   sine_type                   cosine_mag;

   fpvm_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   fpvm_angle #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS)
   ) u_angle (
      .clock               (clock),
      .ctrl                (ctrl),
      .rotor_angle         (req_rotor_angle),
      .angle_is_mechanical (req_angle_is_mechanical),
      .volt_q              (req_volt_q),
      .volt_d              (req_volt_d),
      .pole_pair_count     (pole_pair_count_ff),
      .angle_offset        (angle_offset_ff),
      .rotation_sign       (rotation_sign_ff),
      .electrical_zero     (electrical_zero_ff),
      .sine_addr           (sine_addr),
      .cosine_addr         (cosine_addr),
      .sine_neg            (sine_neg),
      .cosine_neg          (cosine_neg),
      .volt_q_out          (volt_q_st),
      .volt_d_out          (volt_d_st),
      .elec_angle          (elec_angle_st)
   );

   fpvm_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock       (clock),
      .load        (ctrl.mod_load[0]),
      .sine_addr   (sine_addr),
      .cosine_addr (cosine_addr),
      .sine_mag    (sine_mag),
      .cosine_mag  (cosine_mag)
   );

   fpvm_modulate u_modulate (
      .clock             (clock),
      .ctrl              (ctrl),
      .sine_neg          (sine_neg),
      .cosine_neg        (cosine_neg),
      .sine_mag          (sine_mag),
      .cosine_mag        (cosine_mag),
      .volt_q            (volt_q_st),
      .volt_d            (volt_d_st),
      .elec_angle_in     (elec_angle_st),
      .supply_limit      (supply_limit_ff),
      .space_vector_mode (space_vector_mode_ff),
      .center_enable     (center_enable_ff),
      .phase_a           (rsp_phase_a),
      .phase_b           (rsp_phase_b),
      .phase_c           (rsp_phase_c),
      .elec_angle        (rsp_elec_angle)
   );

endmodule
